@@ rtl/xdcp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdcp_pkg
// Shared types, character codes and sizes for the XML document capture parser.
// ----------------------------------------------------------------------------
package xdcp_pkg;

    // Capture store size and derived widths
    localparam int unsigned BUFFER_DEPTH = 512;
    localparam int unsigned PosW         = $clog2(BUFFER_DEPTH);
    localparam int unsigned HdrLen       = 5;
    localparam int unsigned DepthW       = 16;

    // Stream word layout
    localparam int unsigned InW  = 24;
    localparam int unsigned OutW = 24;

    // Command codes
    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Character codes
    localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
    localparam logic [7:0] CH_QM    = 8'h3F;  // '?'
    localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CH_X     = 8'h78;  // 'x'
    localparam logic [7:0] CH_M     = 8'h6D;  // 'm'
    localparam logic [7:0] CH_L     = 8'h6C;  // 'l'
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;

    typedef enum logic [1:0] {
        STAT_NONE     = 2'd0,
        STAT_DONE     = 2'd1,
        STAT_OVERFLOW = 2'd2,
        STAT_READ     = 2'd3
    } t_status;

    typedef enum logic [7:0] {
        PS_FIND_LT   = 8'b0000_0001,
        PS_FIND_QM   = 8'b0000_0010,
        PS_FIND_X    = 8'b0000_0100,
        PS_FIND_M    = 8'b0000_1000,
        PS_FIND_L    = 8'b0001_0000,
        PS_BODY      = 8'b0010_0000,
        PS_TAG_FIRST = 8'b0100_0000,
        PS_TAG_CLOSE = 8'b1000_0000
    } t_parse_state;

    // Header bytes live at fixed positions 0..4 of every capture
    function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = CH_LT;
            3'd1:    ch = CH_QM;
            3'd2:    ch = CH_X;
            3'd3:    ch = CH_M;
            3'd4:    ch = CH_L;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ rtl/xml_document_capture_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_document_capture_parser
// Header-triggered XML document capture with tag depth tracking and readback.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (i_s_*) takes one word per command: feed a stream byte or
//   read one captured byte. Master channel (o_m_*) returns exactly one result
//   word per command, in order: a status code, the read byte and the length
//   of the last complete document.
//   A word accepted loads the middle stage and the registered capture store
//   read, then moves on to the output register, which drives o_m_tvalid.
//   Throughput: one word per cycle while i_m_tready stays high, set by a
//   parse update on each accepted word and the one write / one read port of
//   the capture store.
//   Stall: when i_m_tready is low the output word holds, the middle stage
//   fills, and then o_s_tready drops; nothing is dropped or repeated.
//   Reset (i_rst_n low, synchronous): parser goes back to the header search,
//   position, depth and document length clear, both stages empty. The store
//   is not cleared; only bytes below the latched length are ever returned.
//   Header bytes "<?xml" at positions 0..4 come from constants, the store
//   holds positions 5 and up.
// ----------------------------------------------------------------------------
module xml_document_capture_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // [0] cmd, [8:1] data_byte, [17:9] read_index, [23:18] zero
    input  logic [xdcp_pkg::InW-1:0]  i_s_tdata,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // [1:0] status, [9:2] read_data, [18:10] doc_length, [23:19] zero
    output logic [xdcp_pkg::OutW-1:0] o_m_tdata,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready
);

    localparam int unsigned PosW   = xdcp_pkg::PosW;
    localparam int unsigned DepthW = xdcp_pkg::DepthW;
    localparam logic [PosW-1:0] BufLast = PosW'(xdcp_pkg::BUFFER_DEPTH - 1);
    localparam logic [PosW-1:0] HdrPos  = PosW'(xdcp_pkg::HdrLen);

    // ------------------------------------------------------------------
    // Input word fields
    // ------------------------------------------------------------------
    logic            in_cmd;
    logic [7:0]      in_byte;
    logic [PosW-1:0] in_idx;

    assign in_cmd  = i_s_tdata[0];
    assign in_byte = i_s_tdata[8:1];
    assign in_idx  = i_s_tdata[9 +: PosW];

    // ------------------------------------------------------------------
    // Pipeline control: middle stage s1, output register out
    // ------------------------------------------------------------------
    logic r_s1_valid, r_out_valid;
    logic out_free, s_accept;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || out_free;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    xdcp_pkg::t_parse_state r_state, n_state;
    logic [PosW-1:0]   r_write_pos, n_write_pos;
    logic [DepthW-1:0] r_depth, n_depth;
    logic [PosW-1:0]   r_last_len, n_last_len;
    xdcp_pkg::t_status n_status;
    logic              store_req, store_en, done;
    logic              printable;

    assign printable = (in_byte >= xdcp_pkg::CH_PRINT_LO) &&
                       (in_byte <= xdcp_pkg::CH_PRINT_HI);
    assign store_en  = store_req && printable;

    always_comb begin
        n_state     = r_state;
        n_write_pos = r_write_pos;
        n_depth     = r_depth;
        n_last_len  = r_last_len;
        n_status    = xdcp_pkg::STAT_NONE;
        store_req   = 1'b0;
        done        = 1'b0;

        if (s_accept && in_cmd == xdcp_pkg::CMD_READ) begin
            n_status = xdcp_pkg::STAT_READ;
        end else if (s_accept) begin
            unique case (r_state)
                xdcp_pkg::PS_FIND_LT: begin
                    if (in_byte == xdcp_pkg::CH_LT) n_state = xdcp_pkg::PS_FIND_QM;
                end
                xdcp_pkg::PS_FIND_QM: begin
                    n_state = (in_byte == xdcp_pkg::CH_QM) ? xdcp_pkg::PS_FIND_X
                                                           : xdcp_pkg::PS_FIND_LT;
                end
                xdcp_pkg::PS_FIND_X: begin
                    n_state = (in_byte == xdcp_pkg::CH_X) ? xdcp_pkg::PS_FIND_M
                                                          : xdcp_pkg::PS_FIND_LT;
                end
                xdcp_pkg::PS_FIND_M: begin
                    n_state = (in_byte == xdcp_pkg::CH_M) ? xdcp_pkg::PS_FIND_L
                                                          : xdcp_pkg::PS_FIND_LT;
                end
                xdcp_pkg::PS_FIND_L: begin
                    if (in_byte != xdcp_pkg::CH_L) begin
                        n_state = xdcp_pkg::PS_FIND_LT;
                    end else begin
                        // full header seen: capture resumes after it
                        n_write_pos = HdrPos;
                        n_depth     = '0;
                        n_state     = xdcp_pkg::PS_BODY;
                    end
                end
                xdcp_pkg::PS_BODY: begin
                    if (in_byte == xdcp_pkg::CH_LT) n_state = xdcp_pkg::PS_TAG_FIRST;
                    store_req = 1'b1;
                end
                xdcp_pkg::PS_TAG_FIRST: begin
                    if (in_byte == xdcp_pkg::CH_QM) begin
                        // "<?" re-arms the header match; '?' not kept
                        n_state = xdcp_pkg::PS_FIND_X;
                    end else begin
                        if (in_byte == xdcp_pkg::CH_SLASH) n_depth = r_depth - 1'b1;
                        else                               n_depth = r_depth + 1'b1;
                        store_req = 1'b1;
                        n_state   = xdcp_pkg::PS_TAG_CLOSE;
                    end
                end
                xdcp_pkg::PS_TAG_CLOSE: begin
                    if (in_byte == xdcp_pkg::CH_LT) begin
                        // stray open bracket: drop back to header search
                        n_state = xdcp_pkg::PS_FIND_LT;
                    end else if (in_byte == xdcp_pkg::CH_GT && r_depth == '0) begin
                        store_req = 1'b1;
                        done      = 1'b1;
                        n_state   = xdcp_pkg::PS_FIND_LT;
                    end else begin
                        if (in_byte == xdcp_pkg::CH_GT) n_state = xdcp_pkg::PS_BODY;
                        store_req = 1'b1;
                    end
                end
                default: n_state = xdcp_pkg::PS_FIND_LT;
            endcase

            if (store_en) n_write_pos = r_write_pos + 1'b1;

            if (done) begin
                n_last_len  = r_write_pos + 1'b1;
                n_write_pos = '0;
                n_status    = xdcp_pkg::STAT_DONE;
            end else if (n_write_pos >= BufLast) begin
                // capture would not fit: discard it
                n_write_pos = '0;
                n_state     = xdcp_pkg::PS_FIND_LT;
                n_status    = xdcp_pkg::STAT_OVERFLOW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xdcp_pkg::PS_FIND_LT;
            r_write_pos <= '0;
            r_depth     <= '0;
            r_last_len  <= '0;
        end else begin
            r_state     <= n_state;
            r_write_pos <= n_write_pos;
            r_depth     <= n_depth;
            r_last_len  <= n_last_len;
        end
    end

    // ------------------------------------------------------------------
    // Capture store: one write and one registered read per cycle
    // ------------------------------------------------------------------
    logic [7:0] r_store [xdcp_pkg::BUFFER_DEPTH];
    logic [7:0] r_rd_q;

    always_ff @(posedge i_clk) begin
        if (s_accept && in_cmd == xdcp_pkg::CMD_FEED && store_en) begin
            r_store[r_write_pos] <= in_byte;
        end
        // hold the read word while s1 waits on the output
        if (s_accept && in_cmd == xdcp_pkg::CMD_READ) begin
            r_rd_q <= r_store[in_idx];
        end
    end

    // ------------------------------------------------------------------
    // Stage s1: status, length and read qualifiers next to the store read
    // ------------------------------------------------------------------
    xdcp_pkg::t_status r_s1_status;
    logic [PosW-1:0]   r_s1_len;
    logic              r_s1_hit;
    logic              r_s1_hdr;
    logic [2:0]        r_s1_hdr_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (out_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_status  <= n_status;
            r_s1_len     <= n_last_len;
            r_s1_hit     <= (in_cmd == xdcp_pkg::CMD_READ) && (in_idx < r_last_len);
            r_s1_hdr     <= (in_idx < HdrPos);
            r_s1_hdr_pos <= in_idx[2:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    xdcp_pkg::t_status r_out_status;
    logic [7:0]        r_out_data;
    logic [PosW-1:0]   r_out_len;
    logic [7:0]        s1_data;

    assign s1_data = !r_s1_hit ? 8'h00 :
                     r_s1_hdr  ? xdcp_pkg::hdr_byte(r_s1_hdr_pos) : r_rd_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_status <= r_s1_status;
            r_out_data   <= s1_data;
            r_out_len    <= r_s1_len;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(xdcp_pkg::OutW - 10 - PosW)'(0), r_out_len, r_out_data,
                         r_out_status};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pos_below_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_write_pos < BufLast)
        else $error("capture position reached the overflow mark");

    a_feed_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != xdcp_pkg::STAT_READ |-> r_out_data == 8'h00)
        else $error("read byte on a feed result");

    a_done_min_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == xdcp_pkg::STAT_DONE |-> r_out_len >= PosW'(7))
        else $error("completed document shorter than header and one tag");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_free |-> !s_accept)
        else $error("word accepted into a held stage");

endmodule
